// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl sequencer and datapath modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// consequence must hold in the same cycle as the antecedent
`define ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/dcss_pkg.sv =====
// shared types, constants and helpers of the motor soft start controller
`timescale 1ns / 1ps
package dcss_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int DUTY_W          = 8;
  localparam int DUTY_MAX        = 255;
  localparam int TICKS_W         = 16;
  localparam int PCT_W           = 7;
  localparam int PHASE_W         = 2;
  localparam logic [TICKS_W-1:0] RAMP_TOTAL_RESET = 16'd500;

  typedef enum logic [PHASE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_RAMP = 2'd1,
    MODE_RUN  = 2'd2
  } motor_mode_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic slot_free;
  } ctrl_status_t;

  // d*100/255 truncated: reciprocal estimate plus one correction step
  function automatic logic [PCT_W-1:0] duty_to_percent(input logic [DUTY_W-1:0] d);
    logic [14:0] x;
    logic [23:0] p;
    logic [PCT_W-1:0] q;
    logic [14:0] r;
    x = 15'(d) * 15'd100;
    p = (24'(x) << 8) + 24'(x);
    q = p[22:16];
    r = x - 15'(q) * 15'(DUTY_MAX);
    if (r >= 15'(DUTY_MAX)) begin
      q = q + 7'd1;
    end
    return q;
  endfunction

endpackage

// ===== rtl/dcss_if.sv =====
// channel interfaces: tick input, result output and register write
`timescale 1ns / 1ps

interface dcss_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pot_sample;
  logic                   start_level;
  logic                   stop_level;
  logic                   direction_level;

  modport source (output valid, pot_sample, start_level, stop_level, direction_level,
                  input ready);
  modport sink   (input valid, pot_sample, start_level, stop_level, direction_level,
                  output ready);
endinterface

interface dcss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       pwm_enable;
  logic       bridge_leg_a;
  logic       bridge_leg_b;
  logic [1:0] phase;
  logic       direction_flag;
  logic [6:0] duty_percent;

  modport source (output valid, duty, pwm_enable, bridge_leg_a, bridge_leg_b, phase,
                  direction_flag, duty_percent, input ready);
  modport sink   (input valid, duty, pwm_enable, bridge_leg_a, bridge_leg_b, phase,
                  direction_flag, duty_percent, output ready);
endinterface

interface dcss_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/dcss_ctrl.sv =====
// sequencer for one tick: capture, optional step length divide, commit
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dcss_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dcss_pkg::ctrl_status_t status,
  output dcss_pkg::ctrl_cmd_t    cmd
);
  import dcss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.div_init = (state == ST_EVAL) && status.need_div;
    cmd.div_step = (state == ST_DIV);
    cmd.commit   = (state == ST_EMIT) && status.slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_EVAL;
        end
        ST_EVAL: begin
          state <= status.need_div ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (status.div_last) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.slot_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_eval, clk, rst, in_valid && in_ready, state == ST_EVAL)
  `ASSERT_NEXT(a_div_ends, clk, rst, state == ST_DIV && status.div_last, state == ST_EMIT)
  `ASSERT_NEXT(a_emit_done, clk, rst, state == ST_EMIT && status.slot_free, state == ST_IDLE)

endmodule

// ===== rtl/dcss_datapath.sv =====
// tick datapath: sample scaling, step length divider, ramp state and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dcss_datapath #(
  parameter int SAMPLE_BITS = dcss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcss_pkg::ctrl_cmd_t           cmd,
  output dcss_pkg::ctrl_status_t        status,
  input  logic                          cfg_we,
  input  logic [dcss_pkg::TICKS_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]        pot_sample,
  input  logic                          start_level,
  input  logic                          stop_level,
  input  logic                          direction_level,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dcss_pkg::DUTY_W-1:0]   duty,
  output logic                          pwm_enable,
  output logic                          bridge_leg_a,
  output logic                          bridge_leg_b,
  output logic [dcss_pkg::PHASE_W-1:0]  phase,
  output logic                          direction_flag,
  output logic [dcss_pkg::PCT_W-1:0]    duty_percent
);
  import dcss_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + DUTY_W;
  localparam int CNT_W  = $clog2(TICKS_W);

  logic [TICKS_W-1:0] ramp_total_ticks;

  // captured tick
  logic [DUTY_W-1:0] scaled;
  logic              start_n;
  logic              stop_n;
  logic              dir_lvl;

  // motor state
  motor_mode_t        mode;
  logic               direction;
  logic [DUTY_W-1:0]  ramp_target;
  logic [DUTY_W-1:0]  ramp_duty;
  logic [TICKS_W-1:0] step_length;
  logic [TICKS_W-1:0] step_count;

  // restoring divider, one quotient bit a cycle
  logic [DUTY_W-1:0]  div_rem;
  logic [TICKS_W-1:0] div_quot;
  logic [CNT_W-1:0]   div_cnt;
  logic [DUTY_W:0]    rem_try;
  logic               rem_ge;

  logic [PROD_W-1:0]  prod;

  motor_mode_t        mode_next;
  logic               direction_next;
  logic [DUTY_W-1:0]  ramp_target_next;
  logic [DUTY_W-1:0]  ramp_duty_next;
  logic [TICKS_W-1:0] step_length_next;
  logic [TICKS_W-1:0] step_count_next;
  logic [DUTY_W-1:0]  duty_next;
  logic               check_run;
  logic               active;
  logic [TICKS_W-1:0] len;

  // sample*255 >> SAMPLE_BITS
  assign prod = {pot_sample, {DUTY_W{1'b0}}} - PROD_W'(pot_sample);

  assign rem_try = {div_rem, div_quot[TICKS_W-1]};
  assign rem_ge  = (rem_try >= {1'b0, scaled});

  assign status.need_div  = (mode == MODE_IDLE) && !start_n && (scaled != '0);
  assign status.div_last  = (div_cnt == CNT_W'(TICKS_W - 1));
  assign status.slot_free = !out_valid || out_ready;

  always_comb begin
    mode_next        = mode;
    direction_next   = direction;
    ramp_target_next = ramp_target;
    ramp_duty_next   = ramp_duty;
    step_length_next = step_length;
    step_count_next  = step_count;
    duty_next        = '0;
    check_run        = 1'b0;
    len              = (step_length == '0) ? TICKS_W'(1) : step_length;
    case (mode)
      MODE_IDLE: begin
        direction_next = dir_lvl;
        if (!start_n) begin
          ramp_target_next = scaled;
          ramp_duty_next   = '0;
          if (scaled == '0) begin
            step_length_next = '0;
            step_count_next  = '0;
            mode_next        = MODE_RUN;
            duty_next        = scaled;
          end else begin
            step_length_next = (div_quot == '0) ? TICKS_W'(1) : div_quot;
            step_count_next  = TICKS_W'(1);
            mode_next        = MODE_RAMP;
          end
        end
      end
      MODE_RAMP: begin
        if (step_count >= len) begin
          step_count_next = '0;
          ramp_duty_next  = ramp_duty + 8'd1;
        end
        if (ramp_duty_next >= ramp_target) begin
          mode_next = MODE_RUN;
          check_run = 1'b1;
        end else begin
          step_count_next = step_count_next + 16'd1;
          duty_next       = ramp_duty_next;
        end
      end
      MODE_RUN: begin
        check_run = 1'b1;
      end
      default: begin
        mode_next      = MODE_IDLE;
        direction_next = dir_lvl;
      end
    endcase
    if (check_run) begin
      if (!stop_n) begin
        mode_next = MODE_IDLE;
        duty_next = '0;
      end else begin
        duty_next = scaled;
      end
    end
    active = (mode_next == MODE_RAMP) || (mode_next == MODE_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_total_ticks <= RAMP_TOTAL_RESET;
      mode             <= MODE_IDLE;
      direction        <= 1'b0;
      ramp_target      <= '0;
      ramp_duty        <= '0;
      step_length      <= '0;
      step_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) ramp_total_ticks <= cfg_data;
      if (cmd.commit) begin
        mode        <= mode_next;
        direction   <= direction_next;
        ramp_target <= ramp_target_next;
        ramp_duty   <= ramp_duty_next;
        step_length <= step_length_next;
        step_count  <= step_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scaled  <= prod[PROD_W-1 -: DUTY_W];
      start_n <= start_level;
      stop_n  <= stop_level;
      dir_lvl <= direction_level;
    end
    if (cmd.div_init) begin
      div_rem  <= '0;
      div_quot <= ramp_total_ticks;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= rem_ge ? DUTY_W'(rem_try - {1'b0, scaled}) : rem_try[DUTY_W-1:0];
      div_quot <= {div_quot[TICKS_W-2:0], rem_ge};
      div_cnt  <= div_cnt + CNT_W'(1);
    end
    if (cmd.commit) begin
      duty           <= active ? duty_next : '0;
      pwm_enable     <= active;
      bridge_leg_a   <= active && !direction_next;
      bridge_leg_b   <= active && direction_next;
      phase          <= mode_next;
      direction_flag <= direction_next;
      duty_percent   <= duty_to_percent(scaled);
    end
  end

  `ASSERT_HOLDS(a_ramp_below_target, clk, rst, mode == MODE_RAMP, ramp_duty < ramp_target)
  `ASSERT_HOLDS(a_ramp_len_set, clk, rst, mode == MODE_RAMP, step_length != '0)
  `ASSERT_HOLDS(a_div_from_idle, clk, rst, cmd.div_init, mode == MODE_IDLE && scaled != '0)

endmodule

// ===== rtl/dc_motor_soft_start_controller.sv =====
// top level of the dc motor soft start controller
`timescale 1ns / 1ps
// after the input transfer the sequencer evaluates the tick, runs the restoring divider for
//   the step length on a start tick that begins a ramp, and commits once the result
//   register is free; it handles one tick at a time, so a new tick is taken only after the
//   last one is committed, while the result register may still hold the previous result
// reset: synchronous, active high; motor idle, ramp state cleared, total ticks back to 500
module dc_motor_soft_start_controller #(
  parameter int SAMPLE_BITS = dcss_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dcss_in_if.sink   in_chan,
  dcss_out_if.source out_chan,
  dcss_cfg_if.sink  cfg_chan
);
  import dcss_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // the single register is always writable; writes must come only while idle, which the block does not enforce
  assign cfg_chan.ready = 1'b1;

  // sequencer: accept a tick, run the divide when a ramp starts, commit once
  // the result register is free
  dcss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: scaling, divider, ramp/run state and the result register that
  // decouples the output transfer from the next input transfer
  dcss_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_chan.valid && cfg_chan.ready),
    .cfg_data        (cfg_chan.data),
    .pot_sample      (in_chan.pot_sample),
    .start_level     (in_chan.start_level),
    .stop_level      (in_chan.stop_level),
    .direction_level (in_chan.direction_level),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .duty            (out_chan.duty),
    .pwm_enable      (out_chan.pwm_enable),
    .bridge_leg_a    (out_chan.bridge_leg_a),
    .bridge_leg_b    (out_chan.bridge_leg_b),
    .phase           (out_chan.phase),
    .direction_flag  (out_chan.direction_flag),
    .duty_percent    (out_chan.duty_percent)
  );

endmodule

// ===== tb/dc_motor_soft_start_controller_test.sv =====
// testbench for the dc motor soft start controller: tick stimulus, result prediction and checks
`timescale 1ns / 1ps
module dc_motor_soft_start_controller_test;
  import dcss_pkg::*;

  // one tick as the block sees it; switch levels are active low
  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] pot_sample;
    logic                       start_level;
    logic                       stop_level;
    logic                       direction_level;
  } tick_t;

  // what the motor drive should show for one tick
  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               pwm_enable;
    logic               bridge_leg_a;
    logic               bridge_leg_b;
    logic [PHASE_W-1:0] phase;
    logic               direction_flag;
    logic [PCT_W-1:0]   duty_percent;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dcss_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) tick_ch ();
  dcss_out_if result_ch ();
  dcss_cfg_if ramp_cfg_ch ();

  dc_motor_soft_start_controller #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (tick_ch),
    .out_chan (result_ch),
    .cfg_chan (ramp_cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted motor state, kept in step with every tick handed to the block
  motor_mode_t        motor_mode = MODE_IDLE;
  logic               motor_dir = 1'b0;
  logic [DUTY_W-1:0]  ramp_goal = '0;
  logic [DUTY_W-1:0]  ramp_level = '0;
  logic [TICKS_W-1:0] step_len = '0;
  logic [TICKS_W-1:0] step_cnt = '0;
  logic [TICKS_W-1:0] total_ticks = RAMP_TOTAL_RESET;

  drive_t drive_q[$];      // drive values still owed by the block, oldest first
  int     mismatch_count = 0;
  int     ticks_sent = 0;
  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;

  // advance the predicted motor by one tick and return the drive it should produce
  function automatic drive_t advance_motor(input tick_t t);
    drive_t             d;
    logic [DUTY_W-1:0]  scaled;
    logic [DUTY_W-1:0]  duty_now;
    logic [TICKS_W-1:0] len;
    logic               settle_run;
    logic               active;
    // pot scaled to duty: sample * 255 / 1024, truncated
    scaled = DUTY_W'((18'(t.pot_sample) * 18'(DUTY_MAX)) >> SAMPLE_BITS_DEF);
    duty_now = '0;
    settle_run = 1'b0;
    case (motor_mode)
      MODE_IDLE: begin
        // direction follows its switch only while idle
        motor_dir = t.direction_level;
        if (!t.start_level) begin
          ramp_goal = scaled;
          ramp_level = '0;
          if (scaled == '0) begin
            // zero target: no ramp, straight to run
            step_len = '0;
            step_cnt = '0;
            motor_mode = MODE_RUN;
            duty_now = scaled;
          end else begin
            // the start tick is the first tick of step 0; stop not looked at
            len = total_ticks / TICKS_W'(scaled);
            step_len = (len == '0) ? TICKS_W'(1) : len;
            step_cnt = TICKS_W'(1);
            motor_mode = MODE_RAMP;
          end
        end
      end
      MODE_RAMP: begin
        len = (step_len == '0) ? TICKS_W'(1) : step_len;
        if (step_cnt >= len) begin
          step_cnt = '0;
          ramp_level = ramp_level + DUTY_W'(1);
        end
        if (ramp_level >= ramp_goal) begin
          // ramp end tick behaves as a run tick, so stop counts here
          motor_mode = MODE_RUN;
          settle_run = 1'b1;
        end else begin
          // stop is ignored while ramping
          step_cnt = step_cnt + TICKS_W'(1);
          duty_now = ramp_level;
        end
      end
      MODE_RUN: begin
        settle_run = 1'b1;
      end
      default: begin
        motor_mode = MODE_IDLE;
        motor_dir = t.direction_level;
      end
    endcase
    if (settle_run) begin
      if (!t.stop_level) begin
        motor_mode = MODE_IDLE;
        duty_now = '0;
      end else begin
        duty_now = scaled;
      end
    end
    active = (motor_mode == MODE_RAMP) || (motor_mode == MODE_RUN);
    d.duty = active ? duty_now : '0;
    d.pwm_enable = active;
    d.bridge_leg_a = active && (motor_dir == 1'b0);
    d.bridge_leg_b = active && (motor_dir == 1'b1);
    d.phase = motor_mode;
    d.direction_flag = motor_dir;
    // percent always comes from this tick's pot, whatever the phase
    d.duty_percent = PCT_W'((16'(scaled) * 16'd100) / 16'(DUTY_MAX));
    return d;
  endfunction

  function automatic tick_t make_tick(input int pot, input logic start_n, input logic stop_n,
                                      input logic dir);
    tick_t t;
    t.pot_sample = SAMPLE_BITS_DEF'(pot);
    t.start_level = start_n;
    t.stop_level = stop_n;
    t.direction_level = dir;
    return t;
  endfunction

  function automatic tick_t random_tick();
    return make_tick($urandom_range(0, 1023), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // hand one tick to the block; valid stays high after the transfer so that
  // back to back ticks never see valid dropped and raised in one step
  task automatic send_tick(input tick_t t);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.pot_sample <= t.pot_sample;
    tick_ch.start_level <= t.start_level;
    tick_ch.stop_level <= t.stop_level;
    tick_ch.direction_level <= t.direction_level;
    drive_q.push_back(advance_motor(t));
    ticks_sent++;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // register write, only once every owed result has come back
  task automatic write_ramp_total(input logic [TICKS_W-1:0] value);
    tick_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    ramp_cfg_ch.valid <= 1'b1;
    ramp_cfg_ch.data <= value;
    @(posedge clk);
    while (!ramp_cfg_ch.ready) @(posedge clk);
    ramp_cfg_ch.valid <= 1'b0;
    total_ticks = value;
  endtask

  // result side: random stall, and every transfer checked against the oldest prediction
  always @(posedge clk) begin
    drive_t want;
    result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (drive_q.size() == 0) begin
        $error("result transfer with no tick outstanding");
        mismatch_count++;
      end else begin
        want = drive_q.pop_front();
        if (result_ch.duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, result_ch.duty);
          mismatch_count++;
        end
        if (result_ch.pwm_enable !== want.pwm_enable) begin
          $error("pwm_enable: expected %0d, got %0d", want.pwm_enable, result_ch.pwm_enable);
          mismatch_count++;
        end
        if (result_ch.bridge_leg_a !== want.bridge_leg_a) begin
          $error("bridge_leg_a: expected %0d, got %0d", want.bridge_leg_a,
                 result_ch.bridge_leg_a);
          mismatch_count++;
        end
        if (result_ch.bridge_leg_b !== want.bridge_leg_b) begin
          $error("bridge_leg_b: expected %0d, got %0d", want.bridge_leg_b,
                 result_ch.bridge_leg_b);
          mismatch_count++;
        end
        if (result_ch.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, result_ch.phase);
          mismatch_count++;
        end
        if (result_ch.direction_flag !== want.direction_flag) begin
          $error("direction_flag: expected %0d, got %0d", want.direction_flag,
                 result_ch.direction_flag);
          mismatch_count++;
        end
        if (result_ch.duty_percent !== want.duty_percent) begin
          $error("duty_percent: expected %0d, got %0d", want.duty_percent,
                 result_ch.duty_percent);
          mismatch_count++;
        end
      end
    end
  end

  // idle ticks, a zero target start (with stop held), run tracking and a stop
  task automatic test_idle_and_zero_target();
    send_tick(make_tick(0, 1'b1, 1'b1, 1'b1));
    send_tick(make_tick(1023, 1'b1, 1'b0, 1'b0));    // stop while idle does nothing
    send_tick(make_tick(3, 1'b0, 1'b0, 1'b1));       // start: pot scales to 0, stop not seen
    send_tick(make_tick(1023, 1'b1, 1'b1, 1'b0));    // run at full pot, switch no longer followed
    send_tick(make_tick(512, 1'b0, 1'b1, 1'b0));     // start again while running is ignored
    send_tick(make_tick(700, 1'b1, 1'b0, 1'b0));     // stop: latched direction still shown
    send_tick(make_tick(1023, 1'b1, 1'b1, 1'b0));
  endtask

  // reset total of 500 with a full pot: target 254, one tick per step
  task automatic test_reset_total_ramp();
    send_tick(make_tick(1023, 1'b0, 1'b1, 1'b0));
    while (motor_mode == MODE_RAMP) send_tick(random_tick());
    send_tick(make_tick(600, 1'b1, 1'b0, 1'b1));     // stop from run
  endtask

  // total below its range: every step lasts one tick; stop held through the ramp
  task automatic test_short_total_ramp();
    int n;
    write_ramp_total(TICKS_W'(3));
    send_tick(make_tick(20, 1'b0, 1'b0, 1'b0));      // target 4, start tick shows duty 0
    n = 0;
    while (motor_mode == MODE_RAMP && n < 8) begin
      // the last of these is the ramp end tick, where stop finally acts
      send_tick(make_tick(20 + n, 1'b1, 1'b0, 1'b1));
      n++;
    end
  endtask

  // up to three idle ticks, one start, its ramp, a few run ticks and a stop, all with random
  // content; switch presses that the current phase ignores are left random as noise
  task automatic run_episode();
    tick_t t;
    int    n;
    int    pick;
    n = $urandom_range(0, 3);
    repeat (n) begin
      t = random_tick();
      t.start_level = 1'b1;
      send_tick(t);
    end
    t = random_tick();
    t.start_level = 1'b0;
    // mostly low targets so that ramps stay short when the total is small
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      t.pot_sample = SAMPLE_BITS_DEF'($urandom_range(0, 4));
    end else if (pick <= 14) begin
      t.pot_sample = SAMPLE_BITS_DEF'($urandom_range(5, 200));
    end
    send_tick(t);
    while (motor_mode == MODE_RAMP) send_tick(random_tick());
    n = $urandom_range(1, 6);
    while (n > 0 && motor_mode == MODE_RUN) begin
      t = random_tick();
      t.stop_level = 1'b1;
      send_tick(t);
      n--;
    end
    t = random_tick();
    t.start_level = 1'b1;
    t.stop_level = 1'b0;
    send_tick(t);
  endtask

  task automatic test_random_phase(input int budget, input int sender_pct, input int recv_pct);
    int stop_at;
    sender_idle_pct = sender_pct;
    receiver_stall_pct = recv_pct;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) run_episode();
  endtask

  // largest total: step of 65535/254 ticks, so the duty holds at zero through
  // every ramp tick sent here
  task automatic test_long_total();
    write_ramp_total(TICKS_W'(65535));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_tick(make_tick(1023, 1'b0, 1'b1, 1'b1));
    repeat (20) send_tick(random_tick());
  endtask

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.pot_sample = '0;
    tick_ch.start_level = 1'b1;
    tick_ch.stop_level = 1'b1;
    tick_ch.direction_level = 1'b0;
    ramp_cfg_ch.valid = 1'b0;
    ramp_cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_zero_target();
    // the first ramp runs on the reset total of 500 ticks
    test_reset_total_ramp();
    test_short_total_ramp();
    write_ramp_total(TICKS_W'($urandom_range(1, 40)));
    test_random_phase(20, 0, 0);
    write_ramp_total(TICKS_W'($urandom_range(1, 40)));
    test_random_phase(20, 66, 0);
    write_ramp_total(TICKS_W'($urandom_range(5, 60)));
    test_random_phase(20, 0, 66);
    write_ramp_total(TICKS_W'($urandom_range(1, 40)));
    test_random_phase(20, 6, 6);
    test_long_total();

    // drain what is still owed, then a short settle
    tick_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dc_motor_soft_start_controller verification clean");
    end else begin
      $display("dc_motor_soft_start_controller verification failed");
    end
    $finish;
  end

  // run limit, far above the slowest passing run
  initial begin
    #8000000;
    $display("dc_motor_soft_start_controller verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dcss_pkg.sv
rtl/dcss_if.sv
rtl/dcss_ctrl.sv
rtl/dcss_datapath.sv
rtl/dc_motor_soft_start_controller.sv
tb/dc_motor_soft_start_controller_test.sv
